/* rtl/servo_pump_command_parser_defines.svh */
// ----------------------------------------------------------------------------
// Servo and pump command parser assertion macros
// Shared assertion forms for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef SERVO_PUMP_COMMAND_PARSER_DEFINES_SVH
`define SERVO_PUMP_COMMAND_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SPCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SPCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spcp_pkg.sv */
// ----------------------------------------------------------------------------
// Servo and pump command parser package
// Shared constants, types and command word tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spcp_pkg;

    localparam int LINE_LEN_DEF = 32;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [15:0] US_MIN   = 16'd1000;
    localparam logic [15:0] US_MAX   = 16'd2000;
    localparam logic [30:0] MAG_MAX  = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        REPLY_MOVED    = 2'd0,
        REPLY_PUMP_ON  = 2'd1,
        REPLY_PUMP_OFF = 2'd2,
        REPLY_UNKNOWN  = 2'd3
    } reply_t;

    typedef enum logic [2:0] {
        NUM_SKIP   = 3'b001,
        NUM_DIGITS = 3'b010,
        NUM_DONE   = 3'b100
    } num_phase_t;

    typedef struct packed {
        logic        move_ok;
        logic        on_ok;
        logic        off_ok;
        logic        negative;
        logic [15:0] mag_low;
    } line_status_t;

    function automatic logic [7:0] move_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0: c = 8'h4D;
            2'd1: c = 8'h4F;
            2'd2: c = 8'h56;
            2'd3: c = 8'h45;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "SUCTION O" common to both pump words; the char after it differs
    function automatic logic [7:0] suction_char(input logic [3:0] idx, input logic off_word);
        logic [7:0] c;
        unique case (idx)
            4'd0:  c = 8'h53;
            4'd1:  c = 8'h55;
            4'd2:  c = 8'h43;
            4'd3:  c = 8'h54;
            4'd4:  c = 8'h49;
            4'd5:  c = 8'h4F;
            4'd6:  c = 8'h4E;
            4'd7:  c = 8'h20;
            4'd8:  c = 8'h4F;
            4'd9:  c = off_word ? 8'h46 : 8'h4E;
            4'd10: c = 8'h46;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/servo_pump_command_parser.sv */
// ----------------------------------------------------------------------------
// Servo and pump command parser
// Parses text command lines into servo compare and pump drive updates.
//
//   channel  dir  payload                                   beat
//   s_*      in   tdata[7:0] rx_byte                        one character
//   m_*      out  tdata[11:0] pulse_compare, [12] pump_on;  one reply per
//                 tuser[1:0] reply                          line end
//
// One character per cycle while input is not stalled; a line end gives its
// reply in the cycle after the beat, held in the output register.
// Reset clears the line, servo compare (0) and pump (off).
// Input stalls only while the output register holds an untaken reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "servo_pump_command_parser_defines.svh"

module servo_pump_command_parser #(
    parameter int LINE_LEN = spcp_pkg::LINE_LEN_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [11:0] pulse_compare, [12] pump_on
    output logic [1:0]       m_tuser    // [1:0] reply
);

    logic                   in_beat;
    logic                   line_end;
    spcp_pkg::line_status_t status;

    logic [11:0]            servo_reg, servo_next;
    logic                   pump_reg, pump_next;
    logic                   out_valid_reg;
    spcp_pkg::reply_t       reply_reg, reply_next;
    logic [11:0]            out_cmp_reg;
    logic                   out_pump_reg;

    logic [15:0]            angle;
    logic [15:0]            us_raw;
    logic [15:0]            us_clamp;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign line_end = (s_tdata == spcp_pkg::CHAR_CR) || (s_tdata == spcp_pkg::CHAR_LF);

    spcp_line_parse #(
        .LINE_LEN (LINE_LEN)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_beat && !line_end),
        .clear   (in_beat && line_end),
        .rx_byte (s_tdata),
        .status  (status)
    );

    assign angle    = status.negative ? (16'd0 - status.mag_low) : status.mag_low;
    assign us_raw   = angle + (angle << 1) + (angle << 3) + spcp_pkg::US_MIN;
    assign us_clamp = (us_raw > spcp_pkg::US_MAX) ? spcp_pkg::US_MAX
                    : (us_raw < spcp_pkg::US_MIN) ? spcp_pkg::US_MIN : us_raw;

    always_comb
    begin
        servo_next = servo_reg;
        pump_next  = pump_reg;
        priority if (status.move_ok)
        begin
            servo_next = {us_clamp[10:0], 1'b0};
            reply_next = spcp_pkg::REPLY_MOVED;
        end
        else if (status.on_ok)
        begin
            pump_next  = 1'b1;
            reply_next = spcp_pkg::REPLY_PUMP_ON;
        end
        else if (status.off_ok)
        begin
            pump_next  = 1'b0;
            reply_next = spcp_pkg::REPLY_PUMP_OFF;
        end
        else
            reply_next = spcp_pkg::REPLY_UNKNOWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_reg     <= '0;
            pump_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat && line_end)
            begin
                servo_reg     <= servo_next;
                pump_reg      <= pump_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && line_end)
        begin
            reply_reg    <= reply_next;
            out_cmp_reg  <= servo_next;
            out_pump_reg <= pump_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b0, out_pump_reg, out_cmp_reg};
    assign m_tuser  = reply_reg;

    `SPCP_ASSERT_NEXT(a_line_end_reply, in_beat && line_end, m_tvalid,
        "line end beat gave no reply")
    `SPCP_ASSERT_NOW(a_cmp_range, m_tvalid,
        (m_tdata[11:0] == 12'd0) || ((m_tdata[11:0] >= 12'd2000) && (m_tdata[11:0] <= 12'd4000)),
        "pulse compare out of range")
    `SPCP_ASSERT_NOW(a_pump_on_reply, m_tvalid && (m_tuser == spcp_pkg::REPLY_PUMP_ON),
        m_tdata[12], "pump on reply with pump off")
    `SPCP_ASSERT_NOW(a_pump_off_reply, m_tvalid && (m_tuser == spcp_pkg::REPLY_PUMP_OFF),
        !m_tdata[12], "pump off reply with pump on")

endmodule

`default_nettype wire

/* rtl/spcp_line_parse.sv */
// ----------------------------------------------------------------------------
// Command line parser
// Holds the per-line match flags, length and decimal argument.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spcp_line_parse #(
    parameter int LINE_LEN = spcp_pkg::LINE_LEN_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic                  clear,
    input  wire logic [7:0]            rx_byte,
    output spcp_pkg::line_status_t     status
);

    localparam int POS_W = $clog2(LINE_LEN);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_LEN - 1);
    localparam logic [POS_W-1:0] POS_MOVE  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_ARG   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_ON    = POS_W'(10);
    localparam logic [POS_W-1:0] POS_OFF   = POS_W'(11);

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   ended_reg, ended_next;
    logic                   move_reg, move_next;
    logic                   on_reg, on_next;
    logic                   off_reg, off_next;
    spcp_pkg::num_phase_t   phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [30:0]            mag_reg, mag_next;

    logic                   is_digit;
    logic                   is_blank;
    logic [34:0]            mag_prod;
    logic [30:0]            mag_acc;

    assign is_digit = (rx_byte >= spcp_pkg::CHAR_ZERO) && (rx_byte <= spcp_pkg::CHAR_NINE);
    assign is_blank = ((rx_byte >= spcp_pkg::CHAR_TAB) && (rx_byte <= spcp_pkg::CHAR_CR))
                   || (rx_byte == spcp_pkg::CHAR_SPACE);
    assign mag_prod = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + {31'b0, rx_byte[3:0]};
    assign mag_acc  = (mag_prod > {4'b0, spcp_pkg::MAG_MAX}) ? spcp_pkg::MAG_MAX
                                                           : mag_prod[30:0];

    always_comb
    begin
        pos_next   = pos_reg;
        ended_next = ended_reg;
        move_next  = move_reg;
        on_next    = on_reg;
        off_next   = off_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        if (clear)
        begin
            pos_next   = '0;
            ended_next = 1'b0;
            move_next  = 1'b1;
            on_next    = 1'b1;
            off_next   = 1'b1;
            phase_next = spcp_pkg::NUM_SKIP;
            neg_next   = 1'b0;
            mag_next   = '0;
        end
        else if (step && (pos_reg < POS_LIMIT))
        begin
            pos_next = pos_reg + 1'b1;
            if (!ended_reg)
            begin
                if (rx_byte == spcp_pkg::CHAR_NUL)
                begin
                    // text ends here: apply the length checks
                    ended_next = 1'b1;
                    if (pos_reg < POS_MOVE) move_next = 1'b0;
                    if (pos_reg != POS_ON)  on_next   = 1'b0;
                    if (pos_reg != POS_OFF) off_next  = 1'b0;
                end
                else
                begin
                    if ((pos_reg < POS_MOVE)
                        && (rx_byte != spcp_pkg::move_char(pos_reg[1:0])))
                        move_next = 1'b0;
                    if ((pos_reg >= POS_ON)
                        || (rx_byte != spcp_pkg::suction_char(pos_reg[3:0], 1'b0)))
                        on_next = 1'b0;
                    if ((pos_reg >= POS_OFF)
                        || (rx_byte != spcp_pkg::suction_char(pos_reg[3:0], 1'b1)))
                        off_next = 1'b0;
                    if (pos_reg >= POS_ARG)
                    begin
                        unique case (phase_reg)
                            spcp_pkg::NUM_SKIP:
                            begin
                                priority if (is_blank)
                                    phase_next = spcp_pkg::NUM_SKIP;
                                else if (rx_byte == spcp_pkg::CHAR_PLUS)
                                    phase_next = spcp_pkg::NUM_DIGITS;
                                else if (rx_byte == spcp_pkg::CHAR_MINUS)
                                begin
                                    neg_next   = 1'b1;
                                    phase_next = spcp_pkg::NUM_DIGITS;
                                end
                                else if (is_digit)
                                begin
                                    mag_next   = mag_acc;
                                    phase_next = spcp_pkg::NUM_DIGITS;
                                end
                                else
                                    phase_next = spcp_pkg::NUM_DONE;
                            end
                            spcp_pkg::NUM_DIGITS:
                            begin
                                if (is_digit)
                                    mag_next = mag_acc;
                                else
                                    phase_next = spcp_pkg::NUM_DONE;
                            end
                            default:
                                phase_next = phase_reg;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ended_reg <= 1'b0;
            move_reg  <= 1'b1;
            on_reg    <= 1'b1;
            off_reg   <= 1'b1;
            phase_reg <= spcp_pkg::NUM_SKIP;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            ended_reg <= ended_next;
            move_reg  <= move_next;
            on_reg    <= on_next;
            off_reg   <= off_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

    // line-end view: length checks apply unless the text already ended
    assign status.move_ok  = move_reg && (ended_reg || (pos_reg >= POS_MOVE));
    assign status.on_ok    = on_reg   && (ended_reg || (pos_reg == POS_ON));
    assign status.off_ok   = off_reg  && (ended_reg || (pos_reg == POS_OFF));
    assign status.negative = neg_reg;
    assign status.mag_low  = mag_reg[15:0];

endmodule

`default_nettype wire
